/* design/lprd_pkg.sv */
// package for the length-prefixed record deframer
// holds sizes, register indexes, error codes, phase type and the shared structs
// no dependencies
package lprd_pkg;

  localparam int HeaderBytes       = 16;
  localparam int HdrPosBits        = $clog2(HeaderBytes);
  localparam int DefaultLengthBits = 24;
  localparam int CfgIndexBits      = 3;
  localparam int CfgDataBits       = 32;
  localparam int LimitBits         = 24;

  localparam logic [CfgIndexBits-1:0] RegMagic    = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegMajor    = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegMinor    = 3'd2;
  localparam logic [CfgIndexBits-1:0] RegKindLow  = 3'd3;
  localparam logic [CfgIndexBits-1:0] RegKindHigh = 3'd4;
  localparam logic [CfgIndexBits-1:0] RegLimit    = 3'd5;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrForm   = 2'd1;
  localparam logic [1:0] ErrLength = 2'd2;

  localparam logic [31:0]          MagicReset    = 32'd0;
  localparam logic [7:0]           MajorReset    = 8'd0;
  localparam logic [7:0]           MinorReset    = 8'd0;
  localparam logic [7:0]           KindLowReset  = 8'd0;
  localparam logic [7:0]           KindHighReset = 8'd255;
  localparam logic [LimitBits-1:0] LimitReset    = 24'd65536;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DROP    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [31:0]          magic_word;
    logic [7:0]           major_version;
    logic [7:0]           minor_version;
    logic [7:0]           kind_lowest;
    logic [7:0]           kind_highest;
    logic [LimitBits-1:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [7:0]  record_kind;
    logic [31:0] record_sequence;
    logic        empty_record;
    logic        last;
    logic [1:0]  error_code;
  } result_t;

endpackage

/* design/lprd_cfg_regs.sv */
// configuration registers of the record deframer
// depends on lprd_pkg
module lprd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [lprd_pkg::CfgIndexBits-1:0] wr_index,
  input  logic [lprd_pkg::CfgDataBits-1:0]  wr_data,
  output lprd_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word    <= lprd_pkg::MagicReset;
      cfg.major_version <= lprd_pkg::MajorReset;
      cfg.minor_version <= lprd_pkg::MinorReset;
      cfg.kind_lowest   <= lprd_pkg::KindLowReset;
      cfg.kind_highest  <= lprd_pkg::KindHighReset;
      cfg.payload_limit <= lprd_pkg::LimitReset;
    end else if (wr_en) begin
      case (wr_index)
        lprd_pkg::RegMagic:    cfg.magic_word    <= wr_data;
        lprd_pkg::RegMajor:    cfg.major_version <= wr_data[7:0];
        lprd_pkg::RegMinor:    cfg.minor_version <= wr_data[7:0];
        lprd_pkg::RegKindLow:  cfg.kind_lowest   <= wr_data[7:0];
        lprd_pkg::RegKindHigh: cfg.kind_highest  <= wr_data[7:0];
        lprd_pkg::RegLimit:    cfg.payload_limit <= wr_data[lprd_pkg::LimitBits-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/lprd_in_reg.sv */
// input register of the record deframer, one word deep
// no dependencies
module lprd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  input  logic [7:0] s_byte,
  input  logic       s_drop,
  output logic       s_ready,
  input  logic       take,
  output logic       valid,
  output logic [7:0] data_byte,
  output logic       drop_connection
);

  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data_byte       <= s_byte;
      drop_connection <= s_drop;
    end
  end

endmodule

/* design/lprd_engine.sv */
// framing state and header checks of the record deframer
// depends on lprd_pkg
module lprd_engine #(
  parameter int LengthBits = lprd_pkg::DefaultLengthBits
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        data_byte,
  input  logic              drop_connection,
  input  lprd_pkg::cfg_t    cfg,
  output logic              res_valid,
  output lprd_pkg::result_t res
);

  localparam logic [lprd_pkg::HdrPosBits-1:0] HdrLast =
    lprd_pkg::HdrPosBits'(lprd_pkg::HeaderBytes - 1);

  lprd_pkg::phase_t                phase, phase_next;
  logic [lprd_pkg::HdrPosBits-1:0] hdr_pos, hdr_pos_next;
  logic [LengthBits-1:0]           remaining, remaining_next;
  logic [7:0]                      held_kind, held_kind_next;
  logic [31:0]                     held_sequence, held_sequence_next;
  logic [7:0]                      hdr_store [lprd_pkg::HeaderBytes-1];

  logic [LengthBits-1:0] rem_dec;
  logic [31:0]           magic, length, seq_num;
  logic [7:0]            kind;
  logic                  bad_form, bad_length;

  assign rem_dec  = remaining - LengthBits'(1);
  assign magic    = {hdr_store[0], hdr_store[1], hdr_store[2], hdr_store[3]};
  assign kind     = hdr_store[6];
  assign length   = {hdr_store[8], hdr_store[9], hdr_store[10], hdr_store[11]};
  assign seq_num  = {hdr_store[12], hdr_store[13], hdr_store[14], data_byte};

  assign bad_form = (magic != cfg.magic_word) ||
                    (hdr_store[4] != cfg.major_version) ||
                    (hdr_store[5] != cfg.minor_version) ||
                    (kind < cfg.kind_lowest) || (kind > cfg.kind_highest) ||
                    (hdr_store[7] != 8'd0);
  assign bad_length = (length > 32'(cfg.payload_limit)) ||
                      ((length >> LengthBits) != 32'd0) ||
                      (seq_num == 32'd0);

  always_comb begin
    phase_next         = phase;
    hdr_pos_next       = hdr_pos;
    remaining_next     = remaining;
    held_kind_next     = held_kind;
    held_sequence_next = held_sequence;
    res_valid          = 1'b0;
    res                = '0;
    if (drop_connection) begin
      phase_next         = lprd_pkg::PH_HEADER;
      hdr_pos_next       = '0;
      remaining_next     = '0;
      held_kind_next     = 8'd0;
      held_sequence_next = 32'd0;
    end else begin
      case (phase)
        lprd_pkg::PH_PAYLOAD: begin
          remaining_next      = rem_dec;
          res_valid           = 1'b1;
          res.payload_byte    = data_byte;
          res.record_kind     = held_kind;
          res.record_sequence = held_sequence;
          res.last            = (rem_dec == '0);
          res.error_code      = lprd_pkg::ErrNone;
          if (rem_dec == '0) begin
            phase_next = lprd_pkg::PH_HEADER;
          end
        end
        lprd_pkg::PH_HEADER: begin
          if (hdr_pos != HdrLast) begin
            hdr_pos_next = hdr_pos + 1'b1;
          end else begin
            hdr_pos_next = '0;
            res_valid    = 1'b0;
            if (bad_form) begin
              phase_next     = lprd_pkg::PH_DROP;
              res_valid      = 1'b1;
              res.error_code = lprd_pkg::ErrForm;
            end else if (bad_length) begin
              phase_next     = lprd_pkg::PH_DROP;
              res_valid      = 1'b1;
              res.error_code = lprd_pkg::ErrLength;
            end else begin
              held_kind_next     = kind;
              held_sequence_next = seq_num;
              if (length == 32'd0) begin
                res_valid           = 1'b1;
                res.record_kind     = kind;
                res.record_sequence = seq_num;
                res.empty_record    = 1'b1;
                res.last            = 1'b1;
                res.error_code      = lprd_pkg::ErrNone;
              end else begin
                remaining_next = length[LengthBits-1:0];
                phase_next     = lprd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lprd_pkg::PH_HEADER;
      hdr_pos       <= '0;
      remaining     <= '0;
      held_kind     <= 8'd0;
      held_sequence <= 32'd0;
    end else if (go) begin
      phase         <= phase_next;
      hdr_pos       <= hdr_pos_next;
      remaining     <= remaining_next;
      held_kind     <= held_kind_next;
      held_sequence <= held_sequence_next;
    end
  end

  // header bytes kept until the final one arrives
  always_ff @(posedge clk) begin
    if (go && !drop_connection && (phase == lprd_pkg::PH_HEADER) && (hdr_pos != HdrLast)) begin
      hdr_store[hdr_pos] <= data_byte;
    end
  end

endmodule

/* design/lprd_out_reg.sv */
// result register of the record deframer, one word deep
// depends on lprd_pkg
module lprd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lprd_pkg::result_t res_in,
  output logic              free,
  output logic              m_valid,
  input  logic              m_ready,
  output lprd_pkg::result_t m_res
);

  assign free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res_in;
    end
  end

endmodule

/* design/length_prefixed_record_deframer_core.sv */
// length-prefixed record deframer, top level
// a word accepted into the input register is processed once the result register is free,
// which registers its result, if any; throughput: one word per cycle unless the output
// stalls, set by the single input and result registers
// reset: clears phase, header position, counts, held kind and sequence and sets
// the configuration registers to their defaults; the header store is not cleared
module length_prefixed_record_deframer_core #(
  parameter int LENGTH_BITS = lprd_pkg::DefaultLengthBits
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_byte
  input  logic                              s_tuser,   // drop_connection
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [47:0]                       m_tdata,   // payload_byte, record_kind, record_sequence
  output logic [2:0]                        m_tuser,   // empty_record, error_code
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lprd_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [lprd_pkg::CfgDataBits-1:0]  cfg_data
);

  lprd_pkg::cfg_t    cfg;
  lprd_pkg::result_t res, out_res;
  logic              in_valid, in_drop, res_valid, out_free, go;
  logic [7:0]        in_byte;

  assign cfg_ready = 1'b1;
  assign go        = in_valid && out_free;

  lprd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lprd_in_reg u_in (
    .clk             (clk),
    .rst             (rst),
    .s_valid         (s_tvalid),
    .s_byte          (s_tdata),
    .s_drop          (s_tuser),
    .s_ready         (s_tready),
    .take            (go),
    .valid           (in_valid),
    .data_byte       (in_byte),
    .drop_connection (in_drop)
  );

  lprd_engine #(
    .LengthBits (LENGTH_BITS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .data_byte       (in_byte),
    .drop_connection (in_drop),
    .cfg             (cfg),
    .res_valid       (res_valid),
    .res             (res)
  );

  lprd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (go && res_valid),
    .res_in  (res),
    .free    (out_free),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (out_res)
  );

  assign m_tdata = {out_res.record_sequence, out_res.record_kind, out_res.payload_byte};
  assign m_tuser = {out_res.error_code, out_res.empty_record};
  assign m_tlast = out_res.last;

`ifndef SYNTH
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:1] != lprd_pkg::ErrNone)) |-> ((m_tdata == 48'd0) && !m_tlast))
    else $error("error word carries payload or last");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tuser[2:1] == lprd_pkg::ErrNone)
                                  && (m_tdata[7:0] == 8'd0)))
    else $error("empty record word malformed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");
`endif

endmodule

/* bench/length_prefixed_record_deframer_core_test.sv */
`timescale 1ns / 1ps
// testbench for length_prefixed_record_deframer_core: drives bytes, config writes and
// output stalls, and checks every result word against a scoreboard that predicts records
// depends on lprd_pkg and the core
module length_prefixed_record_deframer_core_test;

  localparam int LenBits = lprd_pkg::DefaultLengthBits;
  localparam logic [lprd_pkg::CfgIndexBits-1:0] RegUnused = 3'd7;
  localparam int SettleCycles = 6;
  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 280;
  localparam int Modes = 6;

  typedef enum int {
    FaultNone, FaultMagic, FaultMajor, FaultMinor, FaultKind, FaultReserved,
    FaultLimit, FaultWide, FaultSeq, FaultBoth
  } fault_t;

  class record_scoreboard;
    lprd_pkg::cfg_t regs;
    lprd_pkg::phase_t ph;
    int unsigned hdr_pos;
    logic [7:0] hdr [lprd_pkg::HeaderBytes];
    logic [LenBits-1:0] remaining;
    logic [7:0] kind_held;
    logic [31:0] seq_held;
    lprd_pkg::result_t awaited [$];
    int unsigned errors;

    function new();
      regs = '{lprd_pkg::MagicReset, lprd_pkg::MajorReset, lprd_pkg::MinorReset,
               lprd_pkg::KindLowReset, lprd_pkg::KindHighReset, lprd_pkg::LimitReset};
      errors = 0;
      restart();
    endfunction

    function void restart();
      ph = lprd_pkg::PH_HEADER;
      hdr_pos = 0;
      remaining = '0;
      kind_held = '0;
      seq_held = '0;
    endfunction

    function void enqueue_result(lprd_pkg::result_t r);
      awaited.insert(awaited.size(), r);
    endfunction

    function void set_reg(logic [lprd_pkg::CfgIndexBits-1:0] idx,
                          logic [lprd_pkg::CfgDataBits-1:0] val);
      case (idx)
        lprd_pkg::RegMagic: regs.magic_word = val;
        lprd_pkg::RegMajor: regs.major_version = val[7:0];
        lprd_pkg::RegMinor: regs.minor_version = val[7:0];
        lprd_pkg::RegKindLow: regs.kind_lowest = val[7:0];
        lprd_pkg::RegKindHigh: regs.kind_highest = val[7:0];
        lprd_pkg::RegLimit: regs.payload_limit = val[lprd_pkg::LimitBits-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic [7:0] b, logic drop);
      lprd_pkg::result_t r;
      logic [31:0] len;
      logic [31:0] seq;
      logic [7:0] kind;
      logic bad_form;
      if (drop) begin
        restart();
        return;
      end
      case (ph)
        lprd_pkg::PH_PAYLOAD: begin
          remaining = remaining - 1'b1;
          r = '{b, kind_held, seq_held, 1'b0, remaining == '0, lprd_pkg::ErrNone};
          enqueue_result(r);
          if (remaining == '0) ph = lprd_pkg::PH_HEADER;
        end
        lprd_pkg::PH_HEADER: begin
          hdr[hdr_pos] = b;
          hdr_pos++;
          if (hdr_pos == lprd_pkg::HeaderBytes) begin
            hdr_pos = 0;
            kind = hdr[6];
            len = {hdr[8], hdr[9], hdr[10], hdr[11]};
            seq = {hdr[12], hdr[13], hdr[14], hdr[15]};
            bad_form = {hdr[0], hdr[1], hdr[2], hdr[3]} != regs.magic_word ||
                       hdr[4] != regs.major_version || hdr[5] != regs.minor_version ||
                       kind < regs.kind_lowest || kind > regs.kind_highest ||
                       hdr[7] != 8'd0;
            if (bad_form) begin
              ph = lprd_pkg::PH_DROP;
              r = '{8'd0, 8'd0, 32'd0, 1'b0, 1'b0, lprd_pkg::ErrForm};
              enqueue_result(r);
            end else if (len > {8'd0, regs.payload_limit} || (len >> LenBits) != 0 ||
                         seq == 32'd0) begin
              ph = lprd_pkg::PH_DROP;
              r = '{8'd0, 8'd0, 32'd0, 1'b0, 1'b0, lprd_pkg::ErrLength};
              enqueue_result(r);
            end else begin
              kind_held = kind;
              seq_held = seq;
              if (len == 32'd0) begin
                r = '{8'd0, kind, seq, 1'b1, 1'b1, lprd_pkg::ErrNone};
                enqueue_result(r);
              end else begin
                remaining = len[LenBits-1:0];
                ph = lprd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void diff_field(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %h got %h", $time, field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(lprd_pkg::result_t got);
      lprd_pkg::result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      diff_field("payload_byte", want.payload_byte, got.payload_byte);
      diff_field("record_kind", want.record_kind, got.record_kind);
      diff_field("record_sequence", want.record_sequence, got.record_sequence);
      diff_field("empty_record", want.empty_record, got.empty_record);
      diff_field("last", want.last, got.last);
      diff_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [47:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [lprd_pkg::CfgIndexBits-1:0] cfg_index;
  logic [lprd_pkg::CfgDataBits-1:0] cfg_data;

  record_scoreboard sb;
  int in_idle_pct;
  int out_idle_pct;
  int unsigned counted;
  int unsigned cycles = 0;

  length_prefixed_record_deframer_core DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result({m_tdata[7:0], m_tdata[15:8], m_tdata[47:16], m_tuser[0], m_tlast,
                       m_tuser[2:1]});
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic drop);
    while ($urandom_range(99) < in_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= drop;
    do @(posedge clk); while (!s_tready);
    if (drop || sb.ph != lprd_pkg::PH_DROP) counted++;
    sb.note_word(b, drop);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [lprd_pkg::CfgIndexBits-1:0] idx,
                           input logic [lprd_pkg::CfgDataBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_settings(input lprd_pkg::cfg_t c);
    write_reg(RegUnused, $urandom);
    write_reg(lprd_pkg::RegMagic, c.magic_word);
    write_reg(lprd_pkg::RegMajor, {24'($urandom), c.major_version});
    write_reg(lprd_pkg::RegMinor, {24'($urandom), c.minor_version});
    write_reg(lprd_pkg::RegKindLow, {24'($urandom), c.kind_lowest});
    write_reg(lprd_pkg::RegKindHigh, {24'($urandom), c.kind_highest});
    write_reg(lprd_pkg::RegLimit, {8'($urandom), c.payload_limit});
    cfg_valid <= 1'b0;
  endtask

  // one record from the current settings with the chosen planted faults, if any;
  // cut_at >= 0 drops the connection before that word
  task automatic send_record(input fault_t fault, input int unsigned len, input int cut_at);
    logic [7:0] hdr_bytes [lprd_pkg::HeaderBytes];
    logic [31:0] length;
    logic [31:0] seq;
    logic [7:0] kind;
    logic [7:0] lo;
    logic [7:0] hi;
    int n;
    lo = sb.regs.kind_lowest;
    hi = sb.regs.kind_highest;
    length = len;
    case ($urandom_range(3))
      0: seq = 32'd1;
      1: seq = 32'hFFFF_FFFF;
      default: seq = $urandom;
    endcase
    if (seq == 32'd0) seq = 32'd1;
    case ($urandom_range(3))
      0: kind = lo;
      1: kind = hi;
      default: kind = 8'($urandom_range(hi, lo));
    endcase
    case (fault)
      FaultKind: begin
        if (hi < 8'd255 && (lo == 8'd0 || $urandom_range(1) == 0))
          kind = 8'($urandom_range(255, hi + 1));
        else if (lo > 8'd0)
          kind = 8'($urandom_range(lo - 1, 0));
      end
      FaultLimit: begin
        if (sb.regs.payload_limit != '1)
          length = sb.regs.payload_limit + 1 + $urandom_range(3);
        else
          length = {8'($urandom_range(255, 1)), 24'($urandom)};
      end
      FaultWide: length = {8'($urandom_range(255, 1)), 24'($urandom)};
      FaultSeq: seq = 32'd0;
      FaultBoth: begin
        length = {8'($urandom_range(255, 1)), 24'($urandom)};
        seq = 32'd0;
      end
      default: ;
    endcase
    {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]} = sb.regs.magic_word;
    hdr_bytes[4] = sb.regs.major_version;
    hdr_bytes[5] = sb.regs.minor_version;
    hdr_bytes[6] = kind;
    hdr_bytes[7] = 8'd0;
    {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]} = length;
    {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]} = seq;
    case (fault)
      FaultMagic, FaultBoth: begin
        n = $urandom_range(3);
        hdr_bytes[n] = hdr_bytes[n] ^ (8'd1 << $urandom_range(7));
      end
      FaultMajor: hdr_bytes[4] = hdr_bytes[4] ^ 8'($urandom_range(255, 1));
      FaultMinor: hdr_bytes[5] = hdr_bytes[5] ^ 8'($urandom_range(255, 1));
      FaultKind: begin
        if (lo == 8'd0 && hi == 8'd255) hdr_bytes[7] = 8'($urandom_range(255, 1));
      end
      FaultReserved: hdr_bytes[7] = 8'($urandom_range(255, 1));
      default: ;
    endcase
    n = 0;
    while (n < lprd_pkg::HeaderBytes || sb.ph == lprd_pkg::PH_PAYLOAD) begin
      if (n == cut_at) begin
        send_word(8'($urandom), 1'b1);
        return;
      end
      send_word((n < lprd_pkg::HeaderBytes) ? hdr_bytes[n] : 8'($urandom), 1'b0);
      n++;
    end
    // after a bad header the block ignores bytes until the connection drops
    if (sb.ph == lprd_pkg::PH_DROP) begin
      repeat ($urandom_range(3)) send_word(8'($urandom), 1'b0);
      send_word(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    lprd_pkg::cfg_t c;
    fault_t fault;
    int unsigned goal;
    int unsigned len;
    int pick;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_pct = 27;
    out_idle_pct = 27;
    counted = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty record, one-byte payload, form error, payload and header drops
    send_record(FaultNone, 0, -1);
    send_record(FaultNone, 1, -1);
    send_record(FaultBoth, 3, -1);
    send_record(FaultNone, 5, 18);
    send_record(FaultNone, 2, 7);

    for (int mode = 0; mode < Modes; mode++) begin
      if (mode > 0) begin
        drain();
        c.magic_word = $urandom;
        c.major_version = 8'($urandom);
        c.minor_version = 8'($urandom);
        c.kind_lowest = 8'($urandom_range(200));
        c.kind_highest = 8'($urandom_range(255, c.kind_lowest));
        c.payload_limit = 24'($urandom_range(64, 1));
        case (mode)
          2: begin
            c.magic_word = '1;
            c.major_version = '1;
            c.minor_version = '1;
            c.kind_highest = c.kind_lowest;
            c.payload_limit = '0;
          end
          3: begin
            // empty kind range
            c.kind_lowest = 8'($urandom_range(255, 1));
            c.kind_highest = 8'($urandom_range(c.kind_lowest - 1, 0));
            c.payload_limit = '1;
          end
          4: begin
            c.magic_word = '0;
            c.major_version = '0;
            c.minor_version = '0;
            c.kind_lowest = '0;
            c.kind_highest = '1;
            c.payload_limit = '1;
          end
          default: ;
        endcase
        apply_settings(c);
      end
      in_idle_pct = (mode == 4) ? 0 : 27;
      out_idle_pct = (mode == 4) ? 0 : 27;
      goal = counted + PhaseWords;
      while (counted < goal) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          repeat ($urandom_range(20, 1)) send_word(8'($urandom), $urandom_range(7) == 0);
          send_word(8'($urandom), 1'b1);
        end else if (pick < 7) begin
          drain();
        end else begin
          fault = (pick < 70) ? FaultNone : fault_t'($urandom_range(FaultBoth, FaultMagic));
          len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
          if (sb.regs.payload_limit <= 64 && $urandom_range(7) == 0)
            len = 32'(sb.regs.payload_limit);
          send_record(fault, len,
                      ($urandom_range(19) == 0) ?
                        $urandom_range(lprd_pkg::HeaderBytes + len) : -1);
        end
      end
    end

    drain();
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
